@@ hw/rtl/dsrp_pkg.sv @@
package dsrp_pkg;

  // Field widths
  localparam int unsigned BASE_W      = 14;
  localparam int unsigned RAW_W       = 12;
  localparam int unsigned SPEED_W     = 14;
  localparam int unsigned TRIM_W      = 4;
  localparam int unsigned SPD_INC_W   = 10;
  localparam int unsigned RAMP_IVL_W  = 20;
  localparam int unsigned STEP_EL_W   = 21;

  // Config port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_SPD_INC       = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_INTERVAL = CFG_ADDR_W'(1);

  localparam logic [SPD_INC_W-1:0]  SPD_INC_RST   = SPD_INC_W'(10);
  localparam logic [RAMP_IVL_W-1:0] RAMP_IVL_RST  = RAMP_IVL_W'(5000);

  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;
  localparam int unsigned LANES                = 2;

  // Per-item control handed from the sequencer to each lane
  typedef struct packed {
    logic run;
    logic rising;
    logic ramp_fire;
  } lane_ctrl_t;

  // Lane status back to the merge stage
  typedef struct packed {
    logic done;
    logic step;
  } lane_stat_t;

endpackage

@@ hw/rtl/dsrp_cfg_if.sv @@
interface dsrp_cfg_if;
  import dsrp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/dsrp_in_if.sv @@
interface dsrp_in_if;
  import dsrp_pkg::*;

  logic              valid;
  logic              ready;
  logic              run;
  logic [BASE_W-1:0] base_speed_a;
  logic [BASE_W-1:0] base_speed_b;
  logic [RAW_W-1:0]  trim_raw_a;
  logic [RAW_W-1:0]  trim_raw_b;

  modport source (output valid, output run, output base_speed_a, output base_speed_b,
                  output trim_raw_a, output trim_raw_b, input ready);
  modport sink   (input valid, input run, input base_speed_a, input base_speed_b,
                  input trim_raw_a, input trim_raw_b, output ready);
endinterface

@@ hw/rtl/dsrp_out_if.sv @@
interface dsrp_out_if;
  import dsrp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     step_a;
  logic                     step_b;
  logic [SPEED_W-1:0]       speed_now_a;
  logic [SPEED_W-1:0]       speed_now_b;
  logic signed [TRIM_W-1:0] trim_pct_a;
  logic signed [TRIM_W-1:0] trim_pct_b;

  modport source (output valid, output step_a, output step_b, output speed_now_a,
                  output speed_now_b, output trim_pct_a, output trim_pct_b, input ready);
  modport sink   (input valid, input step_a, input step_b, input speed_now_a,
                  input speed_now_b, input trim_pct_a, input trim_pct_b, output ready);
endinterface

@@ hw/rtl/dsrp_div.sv @@
// Restoring divider, constant dividend, one quotient bit per clock.
module dsrp_div #(
  parameter int unsigned DIVIDEND = 1000000,
  parameter int unsigned QUOT_W   = 20,
  parameter int unsigned DEN_W    = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEN_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [QUOT_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  assign shifted = {rem_q, acc_q[QUOT_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = QUOT_W'(DIVIDEND);
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      acc_d = {acc_q[QUOT_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

@@ hw/rtl/dsrp_lane.sv @@
// One motor channel: trim, target, ramp, period divide, step decision.
module dsrp_lane #(
  parameter int unsigned TICKS_PER_SECOND = dsrp_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  dsrp_pkg::lane_ctrl_t                ctrl_i,
  input  logic [dsrp_pkg::BASE_W-1:0]         base_i,
  input  logic [dsrp_pkg::RAW_W-1:0]          raw_i,
  input  logic [dsrp_pkg::SPD_INC_W-1:0]      spd_inc_i,
  output dsrp_pkg::lane_stat_t                stat_o,
  output logic [dsrp_pkg::SPEED_W-1:0]        speed_o,
  output logic signed [dsrp_pkg::TRIM_W-1:0]  trim_o
);
  import dsrp_pkg::*;

  localparam int unsigned PER_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned CMP_W = (PER_W + 1 > STEP_EL_W) ? PER_W + 1 : STEP_EL_W;
  localparam int unsigned MAG_W = BASE_W + 3;
  localparam logic [12:0] RECIP_100 = 13'd5243;  // 2^19 / 100, rounded up
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(9999);

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_MUL  = 6'b000010,
    L_TGT  = 6'b000100,
    L_RAMP = 6'b001000,
    L_DIV  = 6'b010000,
    L_STEP = 6'b100000
  } lane_state_e;

  lane_state_e state_q, state_d;

  lane_ctrl_t                ctrl_q;
  logic signed [TRIM_W-1:0]  trim_q;
  logic [MAG_W-1:0]          mag_q;
  logic [SPEED_W-1:0]        tgt_q;
  logic [SPEED_W-1:0]        speed_q, speed_d;
  logic [STEP_EL_W-1:0]      el_q;
  logic                      done_q;
  logic                      step_q;

  // Trim: count thresholds k*4095 that raw*10 reaches, k = 1..10
  logic [15:0]               raw_x10;
  logic [3:0]                trim_cnt;
  logic signed [TRIM_W-1:0]  trim_val;
  logic [2:0]                trim_abs;

  always_comb begin
    raw_x10  = 16'(raw_i) * 16'd10;
    trim_cnt = '0;
    for (int k = 1; k <= 10; k++) begin
      if (raw_x10 >= 16'(k * 4095)) trim_cnt = trim_cnt + 4'd1;
    end
    trim_val = $signed(trim_cnt) - TRIM_W'(5);
  end

  assign trim_abs = trim_q[TRIM_W-1] ? 3'(-trim_q) : 3'(trim_q);

  // Target: base +/- base*|trim|/100, clamped
  logic [29:0]        q_prod;
  logic [9:0]         q_pct;
  logic [BASE_W:0]    tgt_sum;
  logic [SPEED_W-1:0] tgt_clamped;

  assign q_prod = 30'(mag_q) * 30'(RECIP_100);
  assign q_pct  = q_prod[28:19];
  assign tgt_sum = trim_q[TRIM_W-1] ? ({1'b0, base_i} - (BASE_W+1)'(q_pct))
                                    : ({1'b0, base_i} + (BASE_W+1)'(q_pct));
  assign tgt_clamped = (tgt_sum > (BASE_W+1)'(SPEED_MAX)) ? SPEED_MAX : tgt_sum[SPEED_W-1:0];

  // Ramp one step toward target
  logic [SPEED_W:0]   up_sum;
  logic [SPEED_W:0]   dn_lim;
  logic [SPEED_W-1:0] ramped;

  always_comb begin
    up_sum = {1'b0, speed_q} + (SPEED_W+1)'(spd_inc_i);
    dn_lim = {1'b0, tgt_q} + (SPEED_W+1)'(spd_inc_i);
    if (speed_q < tgt_q) begin
      ramped = (up_sum < {1'b0, tgt_q}) ? up_sum[SPEED_W-1:0] : tgt_q;
    end else if ({1'b0, speed_q} > dn_lim) begin
      ramped = speed_q - SPEED_W'(spd_inc_i);
    end else begin
      ramped = tgt_q;
    end
  end

  always_comb begin
    speed_d = speed_q;
    if (!ctrl_q.run) begin
      speed_d = '0;
    end else if (ctrl_q.ramp_fire) begin
      speed_d = ramped;
    end
  end

  // Period divider
  logic             div_done;
  logic [PER_W-1:0] div_quot;

  dsrp_div #(
    .DIVIDEND (TICKS_PER_SECOND),
    .QUOT_W   (PER_W),
    .DEN_W    (SPEED_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == L_RAMP),
    .divisor_i  (speed_d),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Step decision
  logic [CMP_W-1:0] el_x, per_x, per2_x, el_new;
  logic             step_hit;

  always_comb begin
    el_x     = CMP_W'(el_q);
    per_x    = (speed_q == '0) ? '0 : CMP_W'(div_quot);
    per2_x   = per_x << 1;
    step_hit = ctrl_q.run && (per_x != '0) && (el_x >= per_x);
    el_new   = (el_x > per2_x) ? per_x : (el_x - per_x);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE:  if (start_i) state_d = L_MUL;
      L_MUL:   state_d = L_TGT;
      L_TGT:   state_d = L_RAMP;
      L_RAMP:  state_d = L_DIV;
      L_DIV:   if (div_done) state_d = L_STEP;
      L_STEP:  state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      step_q  <= 1'b0;
      speed_q <= '0;
      el_q    <= '0;
      ctrl_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == L_IDLE && start_i) begin
        done_q <= 1'b0;
        ctrl_q <= ctrl_i;
        if (ctrl_i.rising) begin
          el_q <= '0;
        end else if (!(&el_q)) begin
          el_q <= el_q + STEP_EL_W'(1);
        end
      end
      if (state_q == L_RAMP) speed_q <= speed_d;
      if (state_q == L_STEP) begin
        done_q <= 1'b1;
        step_q <= step_hit;
        if (step_hit) el_q <= el_new[STEP_EL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) trim_q <= trim_val;
    if (state_q == L_MUL) mag_q <= MAG_W'(base_i) * MAG_W'(trim_abs);
    if (state_q == L_TGT) tgt_q <= tgt_clamped;
  end

  assign stat_o.done = done_q;
  assign stat_o.step = step_q;
  assign speed_o     = speed_q;
  assign trim_o      = trim_q;

endmodule

@@ hw/rtl/dual_stepper_ramp_pulse_generator_core.sv @@
// Dual stepper trapezoidal ramp step generator. Each input transfer is one
// timer tick (nominally 1 us) carrying run, two base speeds and two 12-bit trim
// samples; each produces exactly one output transfer with the step flags, the
// ramped speeds and the applied trim percents. Two identical lanes (A, B) work
// side by side; each owns its trim mapping, target clamp, ramp and a bit-serial
// period divider (TICKS_PER_SECOND / speed). An item runs from the input
// registers through the prep state and the lane steps (trim product, target,
// ramp, divide, step decision) into the output register, with the divider
// producing one quotient bit per clock. The next tick is taken
// once the result has moved into the output register, even while that result
// still waits for its transfer; a result that has not left when the lanes
// finish holds the lanes and the input. Config writes (speed increment, ramp
// interval) are always accepted and must only be issued while the block is
// idle; unknown addresses are dropped.
module dual_stepper_ramp_pulse_generator_core #(
  parameter int unsigned TICKS_PER_SECOND = dsrp_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsrp_cfg_if.sink    cfg_i,
  dsrp_in_if.sink     in_i,
  dsrp_out_if.source  out_o
);
  import dsrp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_BUSY = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [SPD_INC_W-1:0]   spd_inc_q;
  logic [RAMP_IVL_W-1:0]  ramp_ivl_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_inc_q   <= SPD_INC_RST;
      ramp_ivl_q  <= RAMP_IVL_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.addr == REG_SPD_INC) spd_inc_q <= cfg_i.data[SPD_INC_W-1:0];
      if (cfg_i.addr == REG_RAMP_INTERVAL) ramp_ivl_q <= cfg_i.data[RAMP_IVL_W-1:0];
    end
  end

  // Input capture: held for the whole item
  logic              in_xfer;
  logic              run_q;
  logic              rising_q;
  logic              run_before_q;
  logic [BASE_W-1:0] base_q [LANES];
  logic [RAW_W-1:0]  raw_q  [LANES];
  logic [RAMP_IVL_W-1:0] ramp_el_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Shared ramp timer; fires in the prep cycle
  logic ramp_fire;
  assign ramp_fire = run_q && (ramp_el_q >= ramp_ivl_q);

  lane_ctrl_t lane_ctrl;
  assign lane_ctrl.run       = run_q;
  assign lane_ctrl.rising    = rising_q;
  assign lane_ctrl.ramp_fire = ramp_fire;

  // Lanes
  lane_stat_t               stat  [LANES];
  logic [SPEED_W-1:0]       speed [LANES];
  logic signed [TRIM_W-1:0] trim  [LANES];
  logic [LANES-1:0]         lane_done;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dsrp_lane #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .start_i     (state_q == ST_PREP),
      .ctrl_i      (lane_ctrl),
      .base_i      (base_q[g]),
      .raw_i       (raw_q[g]),
      .spd_inc_i   (spd_inc_q),
      .stat_o      (stat[g]),
      .speed_o     (speed[g]),
      .trim_o      (trim[g])
    );
    assign lane_done[g] = stat[g].done;
  end

  // Merge into the output register once every lane is finished
  logic out_valid_q;
  logic out_load;

  assign out_load = (state_q == ST_BUSY) && (&lane_done) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_PREP;
      ST_PREP: state_d = ST_BUSY;
      ST_BUSY: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      run_before_q <= 1'b0;
      run_q        <= 1'b0;
      rising_q     <= 1'b0;
      ramp_el_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        run_q        <= in_i.run;
        rising_q     <= in_i.run && !run_before_q;
        run_before_q <= in_i.run;
        if (in_i.run && !run_before_q) begin
          ramp_el_q <= '0;
        end else if (!(&ramp_el_q)) begin
          ramp_el_q <= ramp_el_q + RAMP_IVL_W'(1);
        end
      end
      if (state_q == ST_PREP && ramp_fire) ramp_el_q <= '0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      base_q[0] <= in_i.base_speed_a;
      base_q[1] <= in_i.base_speed_b;
      raw_q[0]  <= in_i.trim_raw_a;
      raw_q[1]  <= in_i.trim_raw_b;
    end
  end

  // Output payload
  logic                     step_a_q, step_b_q;
  logic [SPEED_W-1:0]       speed_a_q, speed_b_q;
  logic signed [TRIM_W-1:0] trim_a_q, trim_b_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      step_a_q  <= stat[0].step;
      step_b_q  <= stat[1].step;
      speed_a_q <= speed[0];
      speed_b_q <= speed[1];
      trim_a_q  <= trim[0];
      trim_b_q  <= trim[1];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.step_a      = step_a_q;
  assign out_o.step_b      = step_b_q;
  assign out_o.speed_now_a = speed_a_q;
  assign out_o.speed_now_b = speed_b_q;
  assign out_o.trim_pct_a  = trim_a_q;
  assign out_o.trim_pct_b  = trim_b_q;

endmodule

@@ tb/sv/dsrp_tick_checker.sv @@
module dsrp_tick_checker #(
  parameter int unsigned TICKS_PER_SECOND = dsrp_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsrp_cfg_if         cfg_i,
  dsrp_in_if          in_i,
  dsrp_out_if         out_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);
  import dsrp_pkg::*;

  localparam int unsigned STEP_SAT = (32'd1 << STEP_EL_W) - 1;
  localparam int unsigned RAMP_SAT = (32'd1 << RAMP_IVL_W) - 1;
  localparam int unsigned MAX_SPEED = 9999;

  typedef struct packed {
    logic                     step_a;
    logic                     step_b;
    logic [SPEED_W-1:0]       speed_a;
    logic [SPEED_W-1:0]       speed_b;
    logic signed [TRIM_W-1:0] trim_a;
    logic signed [TRIM_W-1:0] trim_b;
  } tick_result_t;

  // model copy of registers and lane state
  int unsigned spd_inc_r;
  int unsigned ramp_ivl_r;
  logic        run_prev;
  int unsigned speed_r [2];
  int unsigned step_el_r [2];
  int unsigned ramp_el_r;

  tick_result_t expected_ticks_q[$];
  int unsigned  mismatch_cnt;
  int unsigned  result_no;

  function automatic int trim_percent(input logic [RAW_W-1:0] raw);
    int r;
    r = int'(raw);
    return r * 10 / 4095 - 5;
  endfunction

  // signed division truncates toward zero, as required
  function automatic int unsigned speed_target(input logic [BASE_W-1:0] base, input int trim);
    int b;
    int t;
    b = int'(base);
    t = b + (b * trim) / 100;
    if (t < 0) t = 0;
    if (t > int'(MAX_SPEED)) t = MAX_SPEED;
    return t;
  endfunction

  function automatic int unsigned ramp_toward(input int unsigned cur, input int unsigned tgt,
                                              input int unsigned stp);
    if (cur < tgt) return (cur + stp < tgt) ? cur + stp : tgt;
    if (cur > tgt + stp) return cur - stp;
    return tgt;
  endfunction

  task automatic predict_tick(input logic run, input logic [BASE_W-1:0] base_a,
                              input logic [BASE_W-1:0] base_b, input logic [RAW_W-1:0] raw_a,
                              input logic [RAW_W-1:0] raw_b, output tick_result_t res);
    int              trim [2];
    int unsigned     target [2];
    logic            stepped [2];
    longint unsigned period;
    longint unsigned el;
    trim[0] = trim_percent(raw_a);
    trim[1] = trim_percent(raw_b);
    target[0] = speed_target(base_a, trim[0]);
    target[1] = speed_target(base_b, trim[1]);
    stepped[0] = 1'b0;
    stepped[1] = 1'b0;

    // timers restart on a rising edge of run, else count and saturate
    if (run && !run_prev) begin
      step_el_r[0] = 0;
      step_el_r[1] = 0;
      ramp_el_r = 0;
    end else begin
      for (int i = 0; i < 2; i++)
        if (step_el_r[i] < STEP_SAT) step_el_r[i]++;
      if (ramp_el_r < RAMP_SAT) ramp_el_r++;
    end
    run_prev = run;

    if (run) begin
      if (ramp_el_r >= ramp_ivl_r) begin
        ramp_el_r = 0;
        for (int i = 0; i < 2; i++)
          speed_r[i] = ramp_toward(speed_r[i], target[i], spd_inc_r);
      end
      for (int i = 0; i < 2; i++) begin
        period = 0;
        el = step_el_r[i];
        if (speed_r[i] != 0)
          period = longint'(TICKS_PER_SECOND) / longint'(speed_r[i]);
        if (period != 0 && el >= period) begin
          // large backlog snaps back to one period
          if (el > 2 * period) el = period;
          else el = el - period;
          step_el_r[i] = 32'(el);
          stepped[i] = 1'b1;
        end
      end
    end else begin
      speed_r[0] = 0;
      speed_r[1] = 0;
    end

    res.step_a  = stepped[0];
    res.step_b  = stepped[1];
    res.speed_a = SPEED_W'(speed_r[0]);
    res.speed_b = SPEED_W'(speed_r[1]);
    res.trim_a  = TRIM_W'(trim[0]);
    res.trim_b  = TRIM_W'(trim[1]);
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint seen);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("result %0d: %s mismatch, expected %0d, got %0d", result_no, what, want, seen);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst_ni) begin
      spd_inc_r     = SPD_INC_RST;
      ramp_ivl_r    = RAMP_IVL_RST;
      run_prev      = 1'b0;
      speed_r[0]    = 0;
      speed_r[1]    = 0;
      step_el_r[0]  = 0;
      step_el_r[1]  = 0;
      ramp_el_r     = 0;
      mismatch_cnt  = 0;
      result_no     = 0;
      expected_ticks_q.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.addr == REG_SPD_INC)
          spd_inc_r = int'(cfg_i.data[SPD_INC_W-1:0]);
        else if (cfg_i.addr == REG_RAMP_INTERVAL)
          ramp_ivl_r = int'(cfg_i.data[RAMP_IVL_W-1:0]);
      end

      // a result taken at this edge can only belong to an earlier tick
      if (out_i.valid && out_i.ready) begin
        got.step_a  = out_i.step_a;
        got.step_b  = out_i.step_b;
        got.speed_a = out_i.speed_now_a;
        got.speed_b = out_i.speed_now_b;
        got.trim_a  = out_i.trim_pct_a;
        got.trim_b  = out_i.trim_pct_b;
        if (expected_ticks_q.size() == 0) begin
          note_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_ticks_q.pop_front();
          if (got.step_a != want.step_a) note_mismatch("step_a", want.step_a, got.step_a);
          if (got.step_b != want.step_b) note_mismatch("step_b", want.step_b, got.step_b);
          if (got.speed_a != want.speed_a)
            note_mismatch("speed_now_a", want.speed_a, got.speed_a);
          if (got.speed_b != want.speed_b)
            note_mismatch("speed_now_b", want.speed_b, got.speed_b);
          if (got.trim_a != want.trim_a)
            note_mismatch("trim_pct_a", longint'(want.trim_a), longint'(got.trim_a));
          if (got.trim_b != want.trim_b)
            note_mismatch("trim_pct_b", longint'(want.trim_b), longint'(got.trim_b));
        end
        result_no++;
      end

      if (in_i.valid && in_i.ready) begin
        predict_tick(in_i.run, in_i.base_speed_a, in_i.base_speed_b, in_i.trim_raw_a,
                     in_i.trim_raw_b, want);
        expected_ticks_q.push_back(want);
      end

      mismatches_o  <= mismatch_cnt;
      outstanding_o <= expected_ticks_q.size();
    end
  end

endmodule

@@ tb/sv/dual_stepper_ramp_pulse_generator_core_test.sv @@
// Stimulus and verdict for the dual stepper ramp generator. The checker
// beside the block predicts every tick; this module only drives traffic,
// walks through a set of ramp configurations and reports the outcome.
module dual_stepper_ramp_pulse_generator_core_test;
  import dsrp_pkg::*;

  // no transfer of any kind for this many cycles means the block hung
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned PHASES          = 7;
  localparam int unsigned ITEMS_PER_PHASE = 290;
  localparam int unsigned DRAIN_CYCLES    = 60;

  // indexes the block does not decode; writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = CFG_ADDR_W'(3);

  typedef struct packed {
    logic              run;
    logic [BASE_W-1:0] base_a;
    logic [BASE_W-1:0] base_b;
    logic [RAW_W-1:0]  raw_a;
    logic [RAW_W-1:0]  raw_b;
  } tick_t;

  logic clk_i;
  logic rst_ni;

  dsrp_cfg_if cfg_ch ();
  dsrp_in_if  in_ch ();
  dsrp_out_if out_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_cycles;

  // stretches where a side never idles
  bit send_gapless;
  bit recv_gapless;

  // current random segment: a held operating point with some noise on top
  int unsigned seg_left;
  tick_t       seg_tick;

  logic [CFG_ADDR_W-1:0] cfg_addr_q[$];
  logic [CFG_DATA_W-1:0] cfg_data_q[$];

  dual_stepper_ramp_pulse_generator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  dsrp_tick_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_ch),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // single reset at the start
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watchdog on transfers of any channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each result, with gapless stretches
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_ch.ready <= 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_gapless ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      taken++;
      if (taken % 100 == 0) recv_gapless = ($urandom_range(0, 3) == 0);
    end
  end

  // one tick transfer, preceded by a random gap unless in a gapless stretch
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = send_gapless ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.run          <= t.run;
    in_ch.base_speed_a <= t.base_a;
    in_ch.base_speed_b <= t.base_b;
    in_ch.trim_raw_a   <= t.raw_a;
    in_ch.trim_raw_b   <= t.raw_b;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drive(input logic run, input int unsigned ba, input int unsigned bb,
                       input int unsigned ra, input int unsigned rb);
    tick_t t;
    t.run    = run;
    t.base_a = BASE_W'(ba);
    t.base_b = BASE_W'(bb);
    t.raw_a  = RAW_W'(ra);
    t.raw_b  = RAW_W'(rb);
    send_tick(t);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // lanes idle once every tick has produced its result
  task automatic wait_drained();
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_write(input logic [CFG_ADDR_W-1:0] addr, input int unsigned data);
    cfg_addr_q.push_back(addr);
    cfg_data_q.push_back(CFG_DATA_W'(data));
  endtask

  task automatic flush_writes();
    while (cfg_addr_q.size() != 0) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr  <= cfg_addr_q.pop_front();
      cfg_ch.data  <= cfg_data_q.pop_front();
      do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return BASE_W'(9999);
      2:       return BASE_W'($urandom);
      3:       return BASE_W'($urandom_range(9000, 16383));
      default: return BASE_W'($urandom_range(1, 9999));
    endcase
  endfunction

  // mostly held running segments so the ramp and step timers get deep;
  // short stopped segments, raw trim noise and single-tick run glitches
  task automatic next_random_tick(output tick_t t);
    if (seg_left == 0) begin
      seg_tick.run    = ($urandom_range(0, 9) != 0);
      seg_left        = seg_tick.run ? $urandom_range(10, 150) : $urandom_range(1, 8);
      seg_tick.base_a = pick_base();
      seg_tick.base_b = pick_base();
      seg_tick.raw_a  = RAW_W'($urandom);
      seg_tick.raw_b  = RAW_W'($urandom);
      send_gapless    = ($urandom_range(0, 3) == 0);
    end
    seg_left--;
    t = seg_tick;
    if ($urandom_range(0, 15) == 0) begin
      t.raw_a = RAW_W'($urandom);
      t.raw_b = RAW_W'($urandom);
    end
    if ($urandom_range(0, 39) == 0) t.run = ~t.run;
  endtask

  initial begin
    tick_t t;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.addr        <= REG_SPD_INC;
    cfg_ch.data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.run          <= 1'b0;
    in_ch.base_speed_a <= '0;
    in_ch.base_speed_b <= '0;
    in_ch.trim_raw_a   <= '0;
    in_ch.trim_raw_b   <= '0;
    send_gapless = 1'b0;
    seg_left     = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed, reset configuration: trim thresholds, field extremes,
    // trims reported while stopped, first rising edge of run
    drive(1'b0, 0, 0, 0, 0);
    drive(1'b0, 9999, 16383, 4095, 4095);
    drive(1'b0, 150, 1, 409, 410);
    drive(1'b1, 150, 9999, 2047, 2048);
    drive(1'b1, 16383, 0, 4094, 0);
    drive(1'b1, 0, 0, 1, 4095);
    stop_sending();
    wait_drained();

    // ramp on every tick with a big step: clamp above 9999, stop, zero speed
    queue_write(REG_SPD_INC, 1000);
    queue_write(REG_RAMP_INTERVAL, 0);
    flush_writes();
    repeat (6) drive(1'b1, 9999, 16383, 4095, 0);
    drive(1'b0, 9999, 9999, 4095, 4095);
    drive(1'b1, 0, 0, 2048, 2048);
    // negative trim on a small base truncates toward zero
    repeat (2) drive(1'b1, 150, 1, 0, 0);
    repeat (3) drive(1'b1, 16383, 16383, 4095, 4095);

    for (int p = 0; p < PHASES; p++) begin
      stop_sending();
      wait_drained();
      case (p)
        0: begin queue_write(REG_SPD_INC, 250);  queue_write(REG_RAMP_INTERVAL, 0);       end
        1: begin queue_write(REG_SPD_INC, 0);    queue_write(REG_RAMP_INTERVAL, 1);       end
        2: begin queue_write(REG_SPD_INC, 1023); queue_write(REG_RAMP_INTERVAL, 3);       end
        3: begin queue_write(REG_SPD_INC, 37);   queue_write(REG_RAMP_INTERVAL, 1048575); end
        4: begin queue_write(REG_SPD_INC, 1);    queue_write(REG_RAMP_INTERVAL, 1000000); end
        5: begin
          // spare indexes must leave the ramp registers untouched
          queue_write(REG_SPD_INC, $urandom_range(1, 1000));
          queue_write(REG_RAMP_INTERVAL, $urandom_range(0, 20));
          queue_write(REG_SPARE_2, $urandom);
          queue_write(REG_SPARE_3, $urandom);
        end
        default: begin queue_write(REG_SPD_INC, 500); queue_write(REG_RAMP_INTERVAL, 2); end
      endcase
      flush_writes();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        next_random_tick(t);
        send_tick(t);
        // occasional hold-off until every result is back
        if ($urandom_range(0, 199) == 0) begin
          stop_sending();
          wait_drained();
        end
      end
    end

    stop_sending();
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dsrp_pkg.sv
hw/rtl/dsrp_cfg_if.sv
hw/rtl/dsrp_in_if.sv
hw/rtl/dsrp_out_if.sv
hw/rtl/dsrp_div.sv
hw/rtl/dsrp_lane.sv
hw/rtl/dual_stepper_ramp_pulse_generator_core.sv
tb/sv/dsrp_tick_checker.sv
tb/sv/dual_stepper_ramp_pulse_generator_core_test.sv
